### hw/rtl/set_assoc_cache_fifo_lookup_macros.svh
// Assertion macros shared by the cache lookup RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef SET_ASSOC_CACHE_FIFO_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SACF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define SACF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/sacf_pkg.sv
// Package for the set-associative FIFO cache lookup: CSR indexes, field widths, limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sacf_pkg;

   // CSR write channel
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_BLOCK_BITS = 2'd0;
   localparam csr_index_type CSR_SET_BITS   = 2'd1;
   localparam csr_index_type CSR_WAYS       = 2'd2;

   // Register fields
   typedef logic [3:0] block_bits_type;
   typedef logic [2:0] set_bits_type;
   typedef logic [3:0] ways_type;

   localparam block_bits_type BLOCK_BITS_RESET = 4'd2;
   localparam set_bits_type   SET_BITS_RESET   = 3'd2;
   localparam ways_type       WAYS_RESET       = 4'd2;

   localparam block_bits_type BLOCK_BITS_MAX = 4'd12;
   localparam set_bits_type   SET_BITS_MAX   = 3'd6;

   // Request and response fields
   localparam int ADDR_W   = 32;
   localparam int TAG_OUT_W = 32;
   localparam int SET_OUT_W = 6;
   localparam int OFFSET_W = 12;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [TAG_OUT_W-1:0] tag_out_type;
   typedef logic [SET_OUT_W-1:0] set_out_type;
   typedef logic [OFFSET_W-1:0]  offset_type;

endpackage : sacf_pkg
`default_nettype wire

### hw/rtl/set_assoc_cache_fifo_lookup.sv
// Set-associative cache tag lookup with FIFO (round-robin per set) replacement.
// Depends on sacf_pkg and set_assoc_cache_fifo_lookup_macros.svh.
//
// Usage:
//   Request channel: a request (req_address) is taken at a rising edge with start high
//   and busy low. The address is split into byte offset, set index and tag using the
//   block and set sizes held in the CSRs.
//   Response channel: rsp_valid is high for exactly one cycle with rsp_hit, rsp_tag_value,
//   rsp_set_index and rsp_byte_offset. The receiver cannot stall it.
//   CSR channel: csr_index/csr_data are written when csr_valid and csr_ready are high;
//   csr_ready is always high. Write CSRs only while the block is idle.
// Timing:
//   The set row (tags, valid bits, fill pointer) is read from a single-port synchronous
//   memory at the accepting edge; the next cycle compares all ways and, on a miss, writes
//   the modified row back. The response strobe follows in the cycle after that.
//   Because of this read then write-back of one memory row, no new request is taken
//   while busy is high; busy is high for the one compare/write cycle.
// Reset:
//   Clears the CSRs to their defaults and a per-set row-written flag; a set that was
//   never written reads as all lines invalid with its fill pointer at way 0, so no
//   clearing pass runs and requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_fifo_lookup_macros.svh"
module set_assoc_cache_fifo_lookup
   import sacf_pkg::*;
#(
   parameter int MAX_SETS     = 64,
   parameter int MAX_WAYS     = 8,
   parameter int ADDRESS_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          start,
   output logic               busy,
   input  wire addr_type      req_address,
   // response channel
   output logic               rsp_valid,
   output logic               rsp_hit,
   output tag_out_type        rsp_tag_value,
   output set_out_type        rsp_set_index,
   output offset_type         rsp_byte_offset,
   // CSR write channel
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire csr_data_type  csr_data
);

   // Geometry derived from parameters
   localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W   = $clog2(MAX_WAYS + 1);
   localparam int TAG_W   = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
   localparam int SET_FLOOR_LOG2 = $clog2(MAX_SETS + 1) - 1;
   localparam int SET_BITS_LIM   =
      (SET_FLOOR_LOG2 < int'(SET_BITS_MAX)) ? SET_FLOOR_LOG2 : int'(SET_BITS_MAX);
   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
      ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

   // Row layout: tags in the low bits, then valid bits, then the fill pointer
   localparam int VALID_LO = MAX_WAYS * TAG_W;
   localparam int PTR_LO   = VALID_LO + MAX_WAYS;
   localparam int ROW_W    = PTR_LO + WAY_W;

   // CSRs
   block_bits_type cfg_block_bits_ff;
   set_bits_type   cfg_set_bits_ff;
   ways_type       cfg_ways_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_block_bits_ff <= BLOCK_BITS_RESET;
         cfg_set_bits_ff   <= SET_BITS_RESET;
         cfg_ways_ff       <= WAYS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BLOCK_BITS: cfg_block_bits_ff <= csr_data[3:0];
            CSR_SET_BITS:   cfg_set_bits_ff   <= csr_data[2:0];
            CSR_WAYS:       cfg_ways_ff       <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Effective geometry after clamping
   block_bits_type  eff_block_bits;
   set_bits_type    eff_set_bits;
   logic [CNT_W-1:0] eff_ways;
   logic [4:0]      tag_shift;

   always_comb begin
      eff_block_bits = (cfg_block_bits_ff > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX
                                                            : cfg_block_bits_ff;
      eff_set_bits = (int'(cfg_set_bits_ff) > SET_BITS_LIM) ? 3'(SET_BITS_LIM)
                                                            : cfg_set_bits_ff;
      if (cfg_ways_ff == '0) begin
         eff_ways = CNT_W'(1);
      end else if (int'(cfg_ways_ff) > MAX_WAYS) begin
         eff_ways = CNT_W'(MAX_WAYS);
      end else begin
         eff_ways = CNT_W'(cfg_ways_ff);
      end
      tag_shift = 5'(eff_block_bits) + 5'(eff_set_bits);
   end

   // Address split for the incoming request
   logic              accept;
   addr_type          addr_m;
   offset_type        offset_c;
   set_out_type       set_c;
   logic [TAG_W-1:0]  tag_c;
   addr_type          addr_sh;

   assign accept = start && !busy;

   always_comb begin
      addr_m   = req_address & ADDR_MASK;
      offset_c = addr_m[OFFSET_W-1:0] & ~({OFFSET_W{1'b1}} << eff_block_bits);
      addr_sh  = addr_m >> eff_block_bits;
      set_c    = addr_sh[SET_OUT_W-1:0] & ~({SET_OUT_W{1'b1}} << eff_set_bits);
      tag_c    = TAG_W'(addr_m >> tag_shift);
   end

   // Request registers and busy flag
   logic              busy_ff, busy_in;
   set_out_type       set_ff;
   offset_type        offset_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SET_W-1:0]  set_addr;

   assign busy_in  = accept;
   assign busy     = busy_ff;
   assign set_addr = SET_W'(set_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff    <= set_c;
         offset_ff <= offset_c;
         tag_ff    <= tag_c;
      end
   end

   // Row memory: read at accept, written back in the busy cycle on a miss
   logic [ROW_W-1:0] row_mem [MAX_SETS];
   logic [ROW_W-1:0] rd_row_ff;
   logic [ROW_W-1:0] row_in;
   logic             wr_en;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff <= row_mem[SET_W'(set_c)];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[set_addr] <= row_in;
      end
   end

   // Per-set written flag; an unwritten set reads as empty
   logic [MAX_SETS-1:0] row_written_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_written_ff <= '0;
      end else if (wr_en) begin
         row_written_ff[set_addr] <= 1'b1;
      end
   end

   // Compare all ways, choose victim, build the updated row
   logic [ROW_W-1:0] row_c;
   logic             hit_c;
   logic [WAY_W-1:0] ptr_c;
   logic [WAY_W-1:0] victim_c;
   logic [WAY_W-1:0] next_ptr_c;

   always_comb begin
      row_c = row_written_ff[set_addr] ? rd_row_ff : '0;
      hit_c = 1'b0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if ((w < int'(eff_ways)) && row_c[VALID_LO + w] &&
             (row_c[w*TAG_W +: TAG_W] == tag_ff)) begin
            hit_c = 1'b1;
         end
      end
      ptr_c    = row_c[PTR_LO +: WAY_W];
      // stale pointer after the way count shrank restarts at way 0
      victim_c = (int'(ptr_c) < int'(eff_ways)) ? ptr_c : '0;
      next_ptr_c = (int'(victim_c) + 1 >= int'(eff_ways)) ? '0 : WAY_W'(int'(victim_c) + 1);
      row_in = row_c;
      row_in[VALID_LO + int'(victim_c)]        = 1'b1;
      row_in[int'(victim_c)*TAG_W +: TAG_W]    = tag_ff;
      row_in[PTR_LO +: WAY_W]                  = next_ptr_c;
      wr_en  = busy_ff && !hit_c;
   end

   // Response registers
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rsp_hit         <= hit_c;
         rsp_tag_value   <= TAG_OUT_W'(tag_ff);
         rsp_set_index   <= set_ff;
         rsp_byte_offset <= offset_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Assertions
   `SACF_ASSERT_NEXT(a_busy_one_cycle, clock, reset, busy_ff, rsp_valid_ff && !busy_ff,
      "lookup did not finish in one cycle")
   `SACF_ASSERT_IMPL(a_rsp_after_busy, clock, reset, rsp_valid_ff, $past(busy_ff),
      "response without a lookup")
   `SACF_ASSERT_IMPL(a_victim_in_range, clock, reset, wr_en,
      int'(victim_c) < int'(eff_ways), "victim way outside the ways in use")
   `SACF_ASSERT_IMPL(a_no_write_when_idle, clock, reset, !busy_ff, !wr_en,
      "row write outside a lookup")

endmodule : set_assoc_cache_fifo_lookup
`default_nettype wire

### bench/tb_set_assoc_cache_fifo_lookup.sv
// Testbench for set_assoc_cache_fifo_lookup: directed table, then random phases across geometries.
// Depends on sacf_pkg and the block RTL; checks responses against the table or an in-bench model.
`timescale 1ns / 1ps
module tb_set_assoc_cache_fifo_lookup;
   import sacf_pkg::*;

   localparam int SHADOW_SETS     = 64;
   localparam int NUM_WAYS        = 8;
   localparam int PHASES          = 15;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int SETTLE_CYCLES   = 2;

   // index with no register behind it; writes to it must change nothing
   localparam csr_index_type CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic        hit;
      tag_out_type tag_value;
      set_out_type set_index;
      offset_type  byte_offset;
   } lookup_result_type;

   typedef enum logic {ROW_ACCESS, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      csr_index_type     index;
      csr_data_type      data;
      addr_type          address;
      logic              checked;
      lookup_result_type result;
   } stim_row_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   addr_type      req_address;
   logic          rsp_valid;
   logic          rsp_hit;
   tag_out_type   rsp_tag_value;
   set_out_type   rsp_set_index;
   offset_type    rsp_byte_offset;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   csr_data_type  csr_data;

   set_assoc_cache_fifo_lookup i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_tag_value   (rsp_tag_value),
      .rsp_set_index   (rsp_set_index),
      .rsp_byte_offset (rsp_byte_offset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // Shadow of the cache contents and geometry registers
   bit             line_valid_sh [SHADOW_SETS][NUM_WAYS];
   tag_out_type    line_tag_sh   [SHADOW_SETS][NUM_WAYS];
   int unsigned    fill_ptr_sh   [SHADOW_SETS];
   block_bits_type cfg_block = BLOCK_BITS_RESET;
   set_bits_type   cfg_set   = SET_BITS_RESET;
   ways_type       cfg_ways  = WAYS_RESET;

   lookup_result_type expected_lookups [$];
   int unsigned       mismatch_count = 0;
   bit                idling_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Effective geometry after clamping of out-of-range register values
   function automatic int unsigned eff_block_bits();
      return (cfg_block > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : cfg_block;
   endfunction

   function automatic int unsigned eff_set_bits();
      return (cfg_set > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set;
   endfunction

   function automatic int unsigned eff_ways();
      if (cfg_ways == 0) return 1;
      if (cfg_ways > NUM_WAYS) return NUM_WAYS;
      return cfg_ways;
   endfunction

   // Lookup of one address; fills the FIFO victim on a miss
   function automatic lookup_result_type predict_lookup(addr_type a);
      int unsigned       b;
      int unsigned       s;
      int unsigned       ways;
      int unsigned       set_n;
      int unsigned       victim;
      int unsigned       w;
      addr_type          offset;
      tag_out_type       tag;
      lookup_result_type r;
      b      = eff_block_bits();
      s      = eff_set_bits();
      ways   = eff_ways();
      offset = a & ((addr_type'(1) << b) - 1);
      set_n  = (a >> b) & ((addr_type'(1) << s) - 1);
      tag    = a >> (b + s);
      r.hit  = 1'b0;
      for (w = 0; w < ways; w++)
         if (line_valid_sh[set_n][w] && line_tag_sh[set_n][w] == tag) r.hit = 1'b1;
      if (!r.hit) begin
         // stale pointer (ways shrank) restarts at way 0
         victim = fill_ptr_sh[set_n];
         if (victim >= ways) victim = 0;
         line_valid_sh[set_n][victim] = 1'b1;
         line_tag_sh[set_n][victim]   = tag;
         victim++;
         if (victim >= ways) victim = 0;
         fill_ptr_sh[set_n] = victim;
      end
      r.tag_value   = tag;
      r.set_index   = set_out_type'(set_n);
      r.byte_offset = offset_type'(offset);
      return r;
   endfunction

   // No gaps when idling is off; else mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idling_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 2);
      if (roll < 96) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   // Addresses biased towards few tags and sets so that hits and evictions are common
   function automatic addr_type make_address(addr_type tag_seed, addr_type last_addr);
      int unsigned roll;
      int unsigned b;
      int unsigned s;
      addr_type    tag;
      addr_type    set_n;
      roll = $urandom_range(0, 99);
      if (roll < 10) return last_addr;
      if (roll < 25) return $urandom;
      b     = eff_block_bits();
      s     = eff_set_bits();
      tag   = tag_seed ^ $urandom_range(0, 2 * eff_ways() + 1);
      set_n = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
      set_n = set_n & ((addr_type'(1) << s) - 1);
      return (tag << (b + s)) | (set_n << b) | ($urandom & ((addr_type'(1) << b) - 1));
   endfunction

   function automatic stim_row_type access_row(addr_type a);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_ACCESS;
      row.address = a;
      return row;
   endfunction

   function automatic stim_row_type checked_row(addr_type a, logic hit, tag_out_type tag,
                                                set_out_type set_n, offset_type offset);
      stim_row_type row;
      row         = access_row(a);
      row.checked = 1'b1;
      row.result  = '{hit: hit, tag_value: tag, set_index: set_n, byte_offset: offset};
      return row;
   endfunction

   function automatic stim_row_type csr_row(csr_index_type idx, csr_data_type data);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.data  = data;
      return row;
   endfunction

   // One request; the expectation is queued at the accepting edge
   task automatic send_request(addr_type a, logic checked, lookup_result_type given);
      lookup_result_type r;
      int unsigned       gap;
      csr_valid   <= 1'b0;
      start       <= 1'b1;
      req_address <= a;
      do @(posedge clock); while (busy);
      r = predict_lookup(a);
      expected_lookups.push_back(checked ? given : r);
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop both channels and wait for every outstanding response
   task automatic wait_idle();
      start     <= 1'b0;
      csr_valid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes need no toggle
   task automatic write_csr(csr_index_type idx, csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BLOCK_BITS: cfg_block = data;
         CSR_SET_BITS:   cfg_set   = data[2:0];
         CSR_WAYS:       cfg_ways  = data;
         default: ;
      endcase
   endtask

   // Response checker
   always @(posedge clock) begin : check_responses
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_lookups.size() == 0) begin
            $display("%0t: response with none expected, got hit %0d tag %h set %0d off %h",
                     $time, rsp_hit, rsp_tag_value, rsp_set_index, rsp_byte_offset);
            mismatch_count++;
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0d, got %0d", $time, want.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_tag_value !== want.tag_value) begin
               $display("%0t: tag expected %h, got %h", $time, want.tag_value, rsp_tag_value);
               mismatch_count++;
            end
            if (rsp_set_index !== want.set_index) begin
               $display("%0t: set expected %0d, got %0d", $time, want.set_index,
                        rsp_set_index);
               mismatch_count++;
            end
            if (rsp_byte_offset !== want.byte_offset) begin
               $display("%0t: offset expected %h, got %h", $time, want.byte_offset,
                        rsp_byte_offset);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type rows [$];
      addr_type     tag_seed;
      addr_type     last_addr;
      addr_type     a;
      csr_data_type new_block;
      csr_data_type new_set;
      csr_data_type new_ways;
      int           phase;
      int           n;

      reset       <= 1'b1;
      start       <= 1'b0;
      req_address <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_BLOCK_BITS;
      csr_data    <= '0;
      for (int i = 0; i < SHADOW_SETS; i++) begin
         fill_ptr_sh[i] = 0;
         for (int w = 0; w < NUM_WAYS; w++) begin
            line_valid_sh[i][w] = 1'b0;
            line_tag_sh[i][w]   = '0;
         end
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reset geometry (4-byte blocks, 4 sets, 2 ways) first
      rows = '{
         checked_row(32'h0000_0000, 1'b0, 32'h0000_0000, 6'd0, 12'h000),
         checked_row(32'h0000_0000, 1'b1, 32'h0000_0000, 6'd0, 12'h000),
         checked_row(32'hFFFF_FFFF, 1'b0, 32'h0FFF_FFFF, 6'd3, 12'h003),
         checked_row(32'h0000_0010, 1'b0, 32'h0000_0001, 6'd0, 12'h000),
         checked_row(32'h0000_0013, 1'b1, 32'h0000_0001, 6'd0, 12'h003),
         // set full: oldest fill goes first, recent hits do not save a line
         checked_row(32'h0000_0020, 1'b0, 32'h0000_0002, 6'd0, 12'h000),
         checked_row(32'h0000_0000, 1'b0, 32'h0000_0000, 6'd0, 12'h000),
         checked_row(32'h0000_0013, 1'b0, 32'h0000_0001, 6'd0, 12'h003),
         checked_row(32'hFFFF_FFFC, 1'b1, 32'h0FFF_FFFF, 6'd3, 12'h000),
         // oversized registers clamp; zero ways acts as one
         csr_row(CSR_BLOCK_BITS, 4'hF),
         csr_row(CSR_SET_BITS, 4'hF),
         csr_row(CSR_WAYS, 4'h0),
         checked_row(32'hFFFF_FFFF, 1'b0, 32'h0000_3FFF, 6'd63, 12'hFFF),
         checked_row(32'hFFFF_F000, 1'b1, 32'h0000_3FFF, 6'd63, 12'h000),
         // set 0 pointer is now beyond the single way in use
         access_row(32'h0000_0000),
         access_row(32'h0000_0000),
         // growing the ways again exposes the old lines unflushed
         csr_row(CSR_WAYS, 4'h2),
         access_row(32'h0000_0000),
         access_row(32'h0004_0000),
         csr_row(CSR_UNUSED, 4'hF),
         csr_row(CSR_BLOCK_BITS, 4'h0),
         csr_row(CSR_SET_BITS, 4'h0),
         csr_row(CSR_WAYS, 4'hF),
         access_row(32'h0000_0005),
         access_row(32'h8000_0000),
         access_row(32'h0000_0005),
         access_row(32'h7FFF_FFFF),
         csr_row(CSR_WAYS, 4'h8),
         access_row(32'h8000_0000),
         access_row(32'hAAAA_5555),
         access_row(32'h5555_AAAA)
      };
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(rows[i].index, rows[i].data);
         end else begin
            send_request(rows[i].address, rows[i].checked, rows[i].result);
         end
      end

      // Random phases, each under its own geometry
      last_addr = '0;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin new_block = 4'd0;  new_set = 4'd0;  new_ways = 4'd1;  end
            1: begin new_block = 4'd12; new_set = 4'd6;  new_ways = 4'd8;  end
            2: begin new_block = 4'd15; new_set = 4'd15; new_ways = 4'd15; end
            3: begin new_block = 4'd1;  new_set = 4'd3;  new_ways = 4'd0;  end
            default: begin
               new_block = csr_data_type'($urandom_range(0, 3) == 0 ? $urandom_range(13, 15)
                                                                    : $urandom_range(0, 12));
               new_set   = csr_data_type'($urandom_range(0, 15));
               new_ways  = csr_data_type'($urandom_range(0, 4) == 0 ? $urandom_range(0, 15)
                                                                    : $urandom_range(1, 8));
            end
         endcase
         wait_idle();
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_WAYS, new_ways);
            write_csr(CSR_SET_BITS, new_set);
            write_csr(CSR_BLOCK_BITS, new_block);
         end else begin
            write_csr(CSR_BLOCK_BITS, new_block);
            write_csr(CSR_SET_BITS, new_set);
            write_csr(CSR_WAYS, new_ways);
         end
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_UNUSED, csr_data_type'($urandom_range(0, 15)));

         idling_on = (phase % 3) != 1;
         tag_seed  = $urandom;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            a = make_address(tag_seed, last_addr);
            send_request(a, 1'b0, '0);
            last_addr = a;
            if ($urandom_range(0, 99) == 0) wait_idle();
         end
      end

      // Drain and let the pipeline settle
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sacf_pkg.sv
hw/rtl/set_assoc_cache_fifo_lookup.sv
bench/tb_set_assoc_cache_fifo_lookup.sv
